// ===== src/ipd_pkg.sv =====
package ipd_pkg;

  typedef enum logic [1:0] {
    PH_DEAD    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC_BAD  = 3'd1,
    ST_NOT_IMG  = 3'd2,
    ST_SHORT    = 3'd3,
    ST_BAD_META = 3'd4,
    ST_BAD_HDR  = 3'd5,
    ST_OVERSIZE = 3'd6
  } status_e;

  localparam logic [7:0]  MagicB0     = 8'h53;
  localparam logic [7:0]  MagicB1     = 8'h4D;
  localparam logic [7:0]  VersionB    = 8'h01;
  localparam logic [7:0]  TypeImage   = 8'h01;
  localparam logic [7:0]  MetaChannels = 8'd3;
  localparam logic [7:0]  MetaEncoding = 8'd1;
  localparam int unsigned HdrLen      = 24;
  localparam int unsigned MetaLen     = 8;
  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] MaxPayReset = 32'd8388608;
  localparam int unsigned QDepth      = 2;
  localparam logic [0:0]  RegMaxPay   = 1'b0;

  // one byte through the reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  // result beat
  typedef struct packed {
    logic       has_data;
    logic [7:0] image_byte;
    logic       packet_end;
    logic [2:0] status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } res_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       new_stream;
  } tok_t;

endpackage

// ===== src/ipd_stream_if.sv =====
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       new_stream;
  modport source (output valid, stream_byte, new_stream, input ready);
  modport sink   (input valid, stream_byte, new_stream, output ready);
endinterface

interface ipd_out_if;
  logic        valid;
  logic        ready;
  logic        has_data;
  logic [7:0]  image_byte;
  logic        packet_end;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  modport source (output valid, has_data, image_byte, packet_end, status, image_width,
                  image_height, input ready);
  modport sink   (input valid, has_data, image_byte, packet_end, status, image_width,
                  image_height, output ready);
endinterface

// ===== src/image_packet_deframer_crc32.sv =====
// channel | dir | payload
// in_if   | in  | stream_byte[7:0], new_stream
// out_if  | out | has_data, image_byte, packet_end, status, image_width, image_height
// apb     | in  | max_payload_size at address 0
// one byte per cycle sustained while out_if.ready holds; set by the byte-wide crc step in the back end
// a byte is written into the two-entry queue when accepted; a byte that yields a beat reaches the
// result register at the edge that pops it from the queue, once the output register is free
// reset: parser dead until a new_stream byte, max_payload_size = 8388608
// an output stall fills the queue, then in_if.ready drops
module image_packet_deframer_crc32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ipd_in_if.sink      in_if,
  ipd_out_if.source   out_if
);
  logic [31:0]   max_pay_q;
  logic          q_full, q_empty, push, pop;
  ipd_pkg::tok_t tok_in, tok_out;

  // register file
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? max_pay_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pay_q <= ipd_pkg::MaxPayReset;
    end else if (psel && penable && pwrite && paddr == {ipd_pkg::RegMaxPay, 1'b0}) begin
      max_pay_q <= pwdata;
    end
  end

  ipd_front u_front (
    .in_if, .q_full_i(q_full), .push_o(push), .tok_o(tok_in)
  );

  ipd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .tok_i(tok_in), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .tok_o(tok_out)
  );

  ipd_back u_back (
    .clk_i, .rst_ni, .max_pay_i(max_pay_q), .empty_i(q_empty), .tok_i(tok_out),
    .pop_o(pop), .out_if
  );

  // a beat is only shown when it carries data or ends a packet
  a_beat_meaning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.has_data || out_if.packet_end)) else $error("empty beat");

  // status only on a packet end
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.packet_end) |-> out_if.status == ipd_pkg::ST_OK)
    else $error("status without end");

  // never pop an empty queue
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("pop on empty");
endmodule

// ===== src/ipd_front.sv =====
module ipd_front (
  ipd_in_if.sink            in_if,
  input  logic              q_full_i,
  output logic              push_o,
  output ipd_pkg::tok_t     tok_o
);
  assign in_if.ready  = ~q_full_i;
  assign push_o       = in_if.valid & ~q_full_i;
  assign tok_o.data       = in_if.stream_byte;
  assign tok_o.new_stream = in_if.new_stream;
endmodule

// ===== src/ipd_queue.sv =====
module ipd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipd_pkg::tok_t tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ipd_pkg::tok_t tok_o
);
  ipd_pkg::tok_t mem_q [ipd_pkg::QDepth];
  logic [$clog2(ipd_pkg::QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(ipd_pkg::QDepth):0]   cnt_q;

  assign full_o  = (cnt_q == ($clog2(ipd_pkg::QDepth)+1)'(ipd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign tok_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(ipd_pkg::QDepth){1'b0}}, push_i}
                     - {{$clog2(ipd_pkg::QDepth){1'b0}}, pop_i};
    end
  end
endmodule

// ===== src/ipd_back.sv =====
module ipd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   max_pay_i,
  input  logic          empty_i,
  input  ipd_pkg::tok_t tok_i,
  output logic          pop_o,
  ipd_out_if.source     out_if
);
  ipd_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, len_q, len_d, ecrc_q, ecrc_d, crc_q, crc_d;
  logic        hok_q, hok_d;
  logic [7:0]  mtype_q, mtype_d, ch_q, ch_d, enc_q, enc_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic        ovalid_q;
  ipd_pkg::res_t res_q, res_d;
  logic        emit;
  logic        go;

  // output register frees when empty or taken
  assign go    = ~empty_i & (~ovalid_q | out_if.ready);
  assign pop_o = go;

  function automatic ipd_pkg::status_e fstat(input logic [31:0] crc, input logic [31:0] ec,
      input logic [7:0] mt, input logic [31:0] ln, input logic [15:0] w, input logic [15:0] h,
      input logic [7:0] ch, input logic [7:0] en);
    if ((crc ^ ipd_pkg::CrcInit) != ec) return ipd_pkg::ST_CRC_BAD;
    if (mt != ipd_pkg::TypeImage) return ipd_pkg::ST_NOT_IMG;
    if (ln < 32'(ipd_pkg::MetaLen)) return ipd_pkg::ST_SHORT;
    if (!(w != '0 && h != '0 && ch == ipd_pkg::MetaChannels && en == ipd_pkg::MetaEncoding))
      return ipd_pkg::ST_BAD_META;
    return ipd_pkg::ST_OK;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       show, has, last;
    b = tok_i.data;
    phase_d = phase_q; pos_d = pos_q; len_d = len_q; ecrc_d = ecrc_q; crc_d = crc_q;
    hok_d = hok_q; mtype_d = mtype_q; ch_d = ch_q; enc_d = enc_q; w_d = w_q; h_d = h_q;
    res_d = res_q; emit = 1'b0; show = 1'b0; has = 1'b0; last = 1'b0;
    if (go) begin
      if (tok_i.new_stream) begin
        phase_d = ipd_pkg::PH_HEADER;
        pos_d = '0; hok_d = 1'b1; mtype_d = '0; len_d = '0; ecrc_d = '0;
        crc_d = ipd_pkg::CrcInit; w_d = '0; h_d = '0; ch_d = '0; enc_d = '0;
      end
      if (phase_d == ipd_pkg::PH_HEADER) begin
        if (pos_d == 32'd0 && b != ipd_pkg::MagicB0) hok_d = 1'b0;
        if (pos_d == 32'd1 && b != ipd_pkg::MagicB1) hok_d = 1'b0;
        if (pos_d == 32'd2 && b != ipd_pkg::VersionB) hok_d = 1'b0;
        if (pos_d == 32'd3) mtype_d = b;
        if (pos_d >= 32'd16 && pos_d < 32'd20) len_d[8*pos_d[1:0] +: 8] = b;
        if (pos_d >= 32'd20 && pos_d < 32'd24) ecrc_d[8*pos_d[1:0] +: 8] = b;
        res_d = '0;
        if (pos_d + 32'd1 < 32'(ipd_pkg::HdrLen)) begin
          pos_d = pos_d + 32'd1;
        end else if (!hok_d) begin
          emit = 1'b1; res_d.packet_end = 1'b1; res_d.status = ipd_pkg::ST_BAD_HDR;
          phase_d = ipd_pkg::PH_DEAD;
        end else if (len_d > max_pay_i) begin
          emit = 1'b1; res_d.packet_end = 1'b1; res_d.status = ipd_pkg::ST_OVERSIZE;
          phase_d = ipd_pkg::PH_DEAD;
        end else if (len_d == '0) begin
          emit = 1'b1; res_d.packet_end = 1'b1;
          res_d.status = fstat(crc_d, ecrc_d, mtype_d, len_d, w_d, h_d, ch_d, enc_d);
          pos_d = '0; hok_d = 1'b1; mtype_d = '0; ecrc_d = '0; crc_d = ipd_pkg::CrcInit;
        end else begin
          pos_d = '0; phase_d = ipd_pkg::PH_PAYLOAD;
        end
        if (emit && mtype_d == ipd_pkg::TypeImage && len_d >= 32'(ipd_pkg::MetaLen)) begin
          res_d.image_width = w_d; res_d.image_height = h_d;
        end
        if (emit && len_d == '0) len_d = '0;
      end else if (phase_d == ipd_pkg::PH_PAYLOAD) begin
        crc_d = ipd_pkg::crc_byte(crc_d, b);
        unique case (pos_d)
          32'd0:   w_d[7:0]  = b;
          32'd1:   w_d[15:8] = b;
          32'd2:   h_d[7:0]  = b;
          32'd3:   h_d[15:8] = b;
          32'd4:   ch_d = b;
          32'd5:   enc_d = b;
          default: ;
        endcase
        show = (mtype_d == ipd_pkg::TypeImage) && (len_d >= 32'(ipd_pkg::MetaLen));
        has  = show && pos_d >= 32'(ipd_pkg::MetaLen) && w_d != '0 && h_d != '0
               && ch_d == ipd_pkg::MetaChannels && enc_d == ipd_pkg::MetaEncoding;
        last = (pos_d + 32'd1 == len_d);
        res_d = '0;
        res_d.has_data = has;
        res_d.image_byte = has ? b : 8'd0;
        res_d.image_width  = show ? w_d : 16'd0;
        res_d.image_height = show ? h_d : 16'd0;
        if (last) begin
          emit = 1'b1; res_d.packet_end = 1'b1;
          res_d.status = fstat(crc_d, ecrc_d, mtype_d, len_d, w_d, h_d, ch_d, enc_d);
          phase_d = ipd_pkg::PH_HEADER;
          pos_d = '0; hok_d = 1'b1; mtype_d = '0; len_d = '0; ecrc_d = '0;
          crc_d = ipd_pkg::CrcInit; w_d = '0; h_d = '0; ch_d = '0; enc_d = '0;
        end else begin
          pos_d = pos_d + 32'd1;
          emit = has;
        end
      end
    end
    if (!emit && go) res_d = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ipd_pkg::PH_DEAD; pos_q <= '0; len_q <= '0; ecrc_q <= '0;
      crc_q <= ipd_pkg::CrcInit; hok_q <= 1'b1; mtype_q <= '0; ch_q <= '0; enc_q <= '0;
      w_q <= '0; h_q <= '0; ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; len_q <= len_d; ecrc_q <= ecrc_d; crc_q <= crc_d;
      hok_q <= hok_d; mtype_q <= mtype_d; ch_q <= ch_d; enc_q <= enc_d;
      w_q <= w_d; h_q <= h_d;
      if (go) ovalid_q <= emit;
      else if (out_if.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) res_q <= res_d;
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.has_data     = res_q.has_data;
  assign out_if.image_byte   = res_q.image_byte;
  assign out_if.packet_end   = res_q.packet_end;
  assign out_if.status       = res_q.status;
  assign out_if.image_width  = res_q.image_width;
  assign out_if.image_height = res_q.image_height;
endmodule
